[rtl/wrq_pkg.sv]
// Shared types, constants and codes for the waveform residual quality unit.
`default_nettype none
package wrq_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int N_W     = 11;                      // n_points register width
  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int PSUM_W  = PROD_W + $clog2(MAX_POINTS) + 1;
  localparam int SUM_W   = 64;
  localparam int SPK_W   = 16;
  localparam int NSPK_W  = N_W + SPK_W;
  localparam int DVD_W   = 64;
  localparam int DVS_W   = 32;
  localparam int ME_W    = 31;
  localparam int RV_W    = 32;
  localparam int Q_W     = 32;

  localparam logic [1:0] REQ_MEAN  = 2'd0;
  localparam logic [1:0] REQ_SPIKE = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_NO_SPIKE = 2'd1;
  localparam logic [1:0] ST_SILENT   = 2'd2;

  localparam logic [1:0] DSEL_ME = 2'd0;
  localparam logic [1:0] DSEL_RV = 2'd1;
  localparam logic [1:0] DSEL_Q  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] sample;
    logic [15:0]        cluster_id;
  } wrq_in_t;

  typedef struct packed {
    logic [15:0] out_cluster_id;
    logic [30:0] mean_energy;
    logic [31:0] resid_var;
    logic [31:0] q_score;
    logic [15:0] spike_count;
    logic [1:0]  status;
  } wrq_out_t;

  typedef struct packed {
    logic       accept;
    logic       div_start;
    logic [1:0] div_sel;
    logic       latch_me;
    logic       latch_rv;
    logic       latch_q;
    logic       load_out;
  } wrq_cmd_t;

  typedef struct packed {
    logic in_is_end;
    logic pipe_empty;
    logic div_done;
  } wrq_sts_t;

endpackage
`default_nettype wire

[rtl/wrq_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module wrq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[rtl/wrq_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module wrq_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [wrq_pkg::DVD_W-1:0] dividend,
  input  wire logic [wrq_pkg::DVS_W-1:0] divisor,
  output logic      [wrq_pkg::DVD_W-1:0] quotient,
  output logic                           done
);

  localparam int CNT_W = $clog2(wrq_pkg::DVD_W + 1);

  logic [wrq_pkg::DVD_W-1:0] dvd_r, dvd_nxt;
  logic [wrq_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic [wrq_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      done_r, done_nxt;
  logic [wrq_pkg::DVS_W:0]   trial;
  logic                      fits;

  assign trial = {rem_r, dvd_r[wrq_pkg::DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(wrq_pkg::DVD_W);
    end else if (cnt_r != '0) begin
      // shift in one dividend bit, subtract when the divisor fits
      rem_nxt = fits ? wrq_pkg::DVS_W'(trial - {1'b0, dvs_r})
                     : trial[wrq_pkg::DVS_W-1:0];
      dvd_nxt = {dvd_r[wrq_pkg::DVD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient = dvd_r;
  assign done     = done_r;

endmodule
`default_nettype wire

[rtl/wrq_dp.sv]
// Datapath: mean store, sample pipeline, accumulators, divider and result register.
`default_nettype none
module wrq_dp (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire wrq_pkg::wrq_in_t        in_data,
  input  wire logic                    cfg_we,
  input  wire logic [wrq_pkg::N_W-1:0] cfg_data,
  input  wire wrq_pkg::wrq_cmd_t       cmd,
  output wrq_pkg::wrq_sts_t            sts,
  output wrq_pkg::wrq_out_t            out_data
);

  // configuration and effective length
  logic [wrq_pkg::N_W-1:0] n_r;
  logic [wrq_pkg::N_W-1:0] n_eff;

  always_comb begin
    n_eff = n_r;
    if (n_r == '0) begin
      n_eff = wrq_pkg::N_W'(1);
    end else if (n_r > wrq_pkg::N_W'(wrq_pkg::MAX_POINTS)) begin
      n_eff = wrq_pkg::N_W'(wrq_pkg::MAX_POINTS);
    end
  end

  // position and accept stage
  logic [wrq_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      is_mean, is_spike, smp_fire, at_last;

  assign is_mean  = (in_data.req_type == wrq_pkg::REQ_MEAN);
  assign is_spike = (in_data.req_type == wrq_pkg::REQ_SPIKE);
  assign smp_fire = cmd.accept && (is_mean || is_spike);
  assign at_last  = ((wrq_pkg::N_W'(idx_r) + 1'b1) >= n_eff);

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load_out) begin
      idx_nxt = '0;
    end else if (smp_fire) begin
      idx_nxt = at_last ? '0 : idx_r + 1'b1;
    end
  end

  logic [wrq_pkg::SAMPLE_BITS-1:0] ram_rdata;

  wrq_ram #(
    .WIDTH(wrq_pkg::SAMPLE_BITS),
    .DEPTH(wrq_pkg::MAX_POINTS)
  ) u_mean_ram (
    .clk  (clk),
    .we   (cmd.accept && is_mean),
    .addr (idx_r),
    .wdata(in_data.sample[wrq_pkg::SAMPLE_BITS-1:0]),
    .rdata(ram_rdata)
  );

  // stage 1: difference and square
  logic                                   s1_v_r, s1_mean_r, s1_last_r;
  logic signed [wrq_pkg::SAMPLE_BITS-1:0] s1_smp_r;
  logic signed [wrq_pkg::DIFF_W-1:0]      diff;
  logic signed [2*wrq_pkg::DIFF_W-1:0]    sq;

  always_comb begin
    diff = wrq_pkg::DIFF_W'(s1_smp_r);
    if (!s1_mean_r) begin
      diff = wrq_pkg::DIFF_W'(s1_smp_r) - wrq_pkg::DIFF_W'($signed(ram_rdata));
    end
    sq = diff * diff;
  end

  // stage 2: accumulate energy or partial spike sum
  logic                       s2_v_r, s2_mean_r, s2_last_r;
  logic [wrq_pkg::PROD_W-1:0] s2_prod_r;
  logic [wrq_pkg::SUM_W-1:0]  energy_r, energy_nxt;
  logic [wrq_pkg::PSUM_W-1:0] psum_r, psum_nxt, psum_add;

  // stage 3: commit a complete spike
  logic                       s3_v_r, s3_v_nxt;
  logic [wrq_pkg::PSUM_W-1:0] s3_val_r;
  logic [wrq_pkg::SUM_W-1:0]  resid_r, resid_nxt;
  logic [wrq_pkg::SPK_W-1:0]  spk_r, spk_nxt;
  logic [wrq_pkg::SUM_W:0]    resid_add;

  assign psum_add  = psum_r + wrq_pkg::PSUM_W'(s2_prod_r);
  assign resid_add = {1'b0, resid_r} + (wrq_pkg::SUM_W + 1)'(s3_val_r);

  always_comb begin
    energy_nxt = energy_r;
    psum_nxt   = psum_r;
    s3_v_nxt   = 1'b0;
    resid_nxt  = resid_r;
    spk_nxt    = spk_r;
    if (s2_v_r) begin
      if (s2_mean_r) begin
        energy_nxt = energy_r + wrq_pkg::SUM_W'(s2_prod_r);
      end else if (s2_last_r) begin
        psum_nxt = '0;
        s3_v_nxt = 1'b1;
      end else begin
        psum_nxt = psum_add;
      end
    end
    if (s3_v_r && (spk_r != '1)) begin
      resid_nxt = resid_add[wrq_pkg::SUM_W] ? '1 : resid_add[wrq_pkg::SUM_W-1:0];
      spk_nxt   = spk_r + 1'b1;
    end
    if (cmd.load_out) begin
      energy_nxt = '0;
      psum_nxt   = '0;
      resid_nxt  = '0;
      spk_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r       <= wrq_pkg::N_W'(wrq_pkg::MAX_POINTS);
      idx_r     <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      energy_r  <= '0;
      psum_r    <= '0;
      resid_r   <= '0;
      spk_r     <= '0;
    end else begin
      if (cfg_we) begin
        n_r <= cfg_data;
      end
      idx_r    <= idx_nxt;
      s1_v_r   <= smp_fire;
      s2_v_r   <= s1_v_r;
      s3_v_r   <= s3_v_nxt;
      energy_r <= energy_nxt;
      psum_r   <= psum_nxt;
      resid_r  <= resid_nxt;
      spk_r    <= spk_nxt;
    end
    s1_mean_r <= is_mean;
    s1_last_r <= at_last;
    s1_smp_r  <= in_data.sample[wrq_pkg::SAMPLE_BITS-1:0];
    s2_mean_r <= s1_mean_r;
    s2_last_r <= s1_last_r;
    s2_prod_r <= sq[wrq_pkg::PROD_W-1:0];
    s3_val_r  <= psum_add;
  end

  // end of cluster: operands and divider
  logic [15:0]                 id_r;
  logic [wrq_pkg::NSPK_W-1:0]  nspk_r;
  logic [wrq_pkg::ME_W-1:0]    me_r;
  logic [wrq_pkg::RV_W-1:0]    rv_r;
  logic [wrq_pkg::Q_W-1:0]     q_r;
  logic [wrq_pkg::DVD_W-1:0]   div_dvd, div_q;
  logic [wrq_pkg::DVS_W-1:0]   div_dvs;
  logic                        div_done;

  always_comb begin
    case (cmd.div_sel)
      wrq_pkg::DSEL_ME: begin
        div_dvd = energy_r;
        div_dvs = wrq_pkg::DVS_W'(n_eff);
      end
      wrq_pkg::DSEL_RV: begin
        div_dvd = resid_r;
        div_dvs = wrq_pkg::DVS_W'(nspk_r);
      end
      wrq_pkg::DSEL_Q: begin
        div_dvd = {16'b0, rv_r, 16'b0};
        div_dvs = {1'b0, me_r};
      end
      default: begin
        div_dvd = '0;
        div_dvs = '1;
      end
    endcase
  end

  wrq_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .quotient(div_q),
    .done    (div_done)
  );

  // result assembly
  logic [1:0] st;

  always_comb begin
    st = wrq_pkg::ST_VALID;
    if (spk_r == '0) begin
      st = wrq_pkg::ST_NO_SPIKE;
    end else if (me_r == '0) begin
      st = wrq_pkg::ST_SILENT;
    end
  end

  always_ff @(posedge clk) begin
    nspk_r <= wrq_pkg::NSPK_W'(n_eff) * wrq_pkg::NSPK_W'(spk_r);
    if (cmd.accept && (in_data.req_type == wrq_pkg::REQ_END)) begin
      id_r <= in_data.cluster_id;
    end
    if (cmd.latch_me) begin
      me_r <= (|div_q[wrq_pkg::DVD_W-1:wrq_pkg::ME_W]) ? '1 : div_q[wrq_pkg::ME_W-1:0];
    end
    if (cmd.latch_rv) begin
      rv_r <= (|div_q[wrq_pkg::DVD_W-1:wrq_pkg::RV_W]) ? '1 : div_q[wrq_pkg::RV_W-1:0];
    end
    if (cmd.latch_q) begin
      q_r <= (|div_q[wrq_pkg::DVD_W-1:wrq_pkg::Q_W]) ? '1 : div_q[wrq_pkg::Q_W-1:0];
    end
    if (cmd.load_out) begin
      out_data.out_cluster_id <= id_r;
      out_data.mean_energy    <= me_r;
      out_data.resid_var      <= (st == wrq_pkg::ST_NO_SPIKE) ? '0 : rv_r;
      out_data.q_score        <= (st == wrq_pkg::ST_NO_SPIKE) ? '0 :
                                 (st == wrq_pkg::ST_SILENT)   ? '1 : q_r;
      out_data.spike_count    <= spk_r;
      out_data.status         <= st;
    end
  end

  assign sts.in_is_end  = (in_data.req_type == wrq_pkg::REQ_END);
  assign sts.pipe_empty = !(s1_v_r || s2_v_r || s3_v_r);
  assign sts.div_done   = div_done;

endmodule
`default_nettype wire

[rtl/wrq_ctrl.sv]
// Controller: input acceptance, end-of-cluster sequencing and result handshake.
`default_nettype none
module wrq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire wrq_pkg::wrq_sts_t sts,
  output wrq_pkg::wrq_cmd_t      cmd
);

  localparam logic [3:0] S_RUN   = 4'd0;
  localparam logic [3:0] S_DRAIN = 4'd1;
  localparam logic [3:0] S_MEGO  = 4'd2;
  localparam logic [3:0] S_ME    = 4'd3;
  localparam logic [3:0] S_RVGO  = 4'd4;
  localparam logic [3:0] S_RV    = 4'd5;
  localparam logic [3:0] S_QGO   = 4'd6;
  localparam logic [3:0] S_Q     = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       out_free;

  assign in_ready = (state_r == S_RUN);
  assign out_free = !ov_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.accept = in_valid && in_ready;
    ov_nxt    = ov_r && !out_ready;
    case (state_r)
      S_RUN: begin
        if (cmd.accept && sts.in_is_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = S_MEGO;
        end
      end
      S_MEGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = wrq_pkg::DSEL_ME;
        state_nxt     = S_ME;
      end
      S_ME: begin
        if (sts.div_done) begin
          cmd.latch_me = 1'b1;
          state_nxt    = S_RVGO;
        end
      end
      S_RVGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = wrq_pkg::DSEL_RV;
        state_nxt     = S_RV;
      end
      S_RV: begin
        if (sts.div_done) begin
          cmd.latch_rv = 1'b1;
          state_nxt    = S_QGO;
        end
      end
      S_QGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = wrq_pkg::DSEL_Q;
        state_nxt     = S_Q;
      end
      S_Q: begin
        if (sts.div_done) begin
          cmd.latch_q = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free, then load and clear the cluster
        if (out_free) begin
          cmd.load_out = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

endmodule
`default_nettype wire

[rtl/waveform_residual_quality_unit.sv]
// Top level of the waveform residual quality unit.
// Usage:
//   Stream one cluster as n_points mean samples (req_type 0), then the spike
//   samples in the same order (req_type 1), then one end item (req_type 2).
//   Each item moves on in_valid/in_ready; an end item's single result leaves
//   on out_valid/out_ready. n_points (reset 1024) goes on cfg_valid/cfg_ready
//   (always ready); the user writes it only while idle; no check is made.
// Sample flow and end-of-cluster sequence:
//   Sample items are taken one per cycle, back to back, while no end item is
//   in progress; each runs through a three-stage pipe (mean store read,
//   square, accumulate/commit). An end item waits for that pipe to drain, then
//   runs three divisions on one shared restoring divider at one quotient bit
//   per cycle. No input is taken until its result is loaded into the output
//   register.
// Stalls and reset:
//   The result sits in an output register; a stalled receiver holds input
//   back only once the next end item has finished its divisions, so samples
//   of the next cluster keep flowing.
//   Reset (rst_n low, synchronous) clears all sums, counts and the position;
//   the mean store is not cleared and needs no clearing pass.
`default_nettype none
module waveform_residual_quality_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire wrq_pkg::wrq_in_t        in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output wrq_pkg::wrq_out_t            out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [wrq_pkg::N_W-1:0] cfg_data
);

  wrq_pkg::wrq_cmd_t cmd;
  wrq_pkg::wrq_sts_t sts;

  // configuration is taken in any cycle
  assign cfg_ready = 1'b1;

  // sequence acceptance, division steps and the result handshake
  wrq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold the mean store, sums, divider and result register
  wrq_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for the waveform residual quality unit: directed and random clusters.
`timescale 1ns / 1ps
module tb;

  // Request code that the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  wrq_pkg::wrq_in_t          in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  wrq_pkg::wrq_out_t         out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [wrq_pkg::N_W-1:0]   cfg_data  = '0;

  waveform_residual_quality_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[waveform_residual_quality_unit] ERROR");
    $finish;
  end

  // ------------------------------------------------------------------
  // Predictor state: a private copy of the cluster accumulators
  // ------------------------------------------------------------------
  logic signed [15:0] mean_mem [wrq_pkg::MAX_POINTS];
  bit                 mean_seen [wrq_pkg::MAX_POINTS];   // entry written at least once
  int unsigned        pts_reg     = 1024;       // n_points as last written
  int unsigned        pos_idx     = 0;
  logic [63:0]        energy_acc  = '0;
  logic [63:0]        resid_acc   = '0;
  logic [63:0]        partial_acc = '0;
  int unsigned        spikes_acc  = 0;
  wrq_pkg::wrq_out_t  pending_scores[$];        // scores still owed by the block

  int unsigned        err_count    = 0;
  int unsigned        items_sent   = 0;
  bit                 in_idle_en   = 1'b1;
  bit                 out_idle_en  = 1'b1;
  int unsigned        out_wait     = 0;
  wrq_pkg::wrq_out_t  score_want;

  function automatic int unsigned eff_points();
    if (pts_reg == 0) return 1;
    if (pts_reg > wrq_pkg::MAX_POINTS) return wrq_pkg::MAX_POINTS;
    return pts_reg;
  endfunction

  // Apply one accepted item to the predictor; queue the score on an end item.
  task automatic score_item(input wrq_pkg::wrq_in_t it);
    int unsigned       n;
    int unsigned       pos;
    longint            s;
    longint            d;
    logic [63:0]       sum;
    logic [63:0]       me;
    logic [63:0]       rv;
    logic [63:0]       q;
    wrq_pkg::wrq_out_t r;
    n   = eff_points();
    pos = pos_idx % wrq_pkg::MAX_POINTS;
    s   = $signed(it.sample);
    case (it.req_type)
      wrq_pkg::REQ_MEAN: begin
        mean_mem[pos]  = it.sample;
        mean_seen[pos] = 1'b1;
        energy_acc     = energy_acc + 64'(s * s);
        pos_idx        = (pos_idx + 1 >= n) ? 0 : pos_idx + 1;
      end
      wrq_pkg::REQ_SPIKE: begin
        d           = s - mean_mem[pos];
        partial_acc = partial_acc + 64'(d * d);
        // last position closes the spike; drop it once the count is full
        if (pos_idx + 1 >= n) begin
          if (spikes_acc < 65535) begin
            sum        = resid_acc + partial_acc;
            resid_acc  = (sum < resid_acc) ? '1 : sum;
            spikes_acc = spikes_acc + 1;
          end
          partial_acc = '0;
        end
        pos_idx = (pos_idx + 1 >= n) ? 0 : pos_idx + 1;
      end
      wrq_pkg::REQ_END: begin
        me = energy_acc / n;
        if (me > 64'h7FFF_FFFF) me = 64'h7FFF_FFFF;
        rv = '0;
        q  = '0;
        if (spikes_acc == 0) begin
          r.status = wrq_pkg::ST_NO_SPIKE;
        end else begin
          rv = resid_acc / (64'(n) * 64'(spikes_acc));
          if (rv > 64'hFFFF_FFFF) rv = 64'hFFFF_FFFF;
          if (me == 0) begin
            r.status = wrq_pkg::ST_SILENT;
            q        = 64'hFFFF_FFFF;
          end else begin
            r.status = wrq_pkg::ST_VALID;
            q        = (rv << 16) / me;
            if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
          end
        end
        r.out_cluster_id = it.cluster_id;
        r.mean_energy    = me[30:0];
        r.resid_var      = rv[31:0];
        r.q_score        = q[31:0];
        r.spike_count    = spikes_acc[15:0];
        pending_scores   = {pending_scores, r};
        pos_idx     = 0;
        energy_acc  = '0;
        resid_acc   = '0;
        partial_acc = '0;
        spikes_acc  = 0;
      end
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic logic [15:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) return 16'h8000;
    if (pick < 4) return 16'h7FFF;
    if (pick == 4) return 16'h0000;
    return 16'($urandom);
  endfunction

  // Spike sample close to the stored mean at the current position
  function automatic logic [15:0] near_mean();
    int unsigned pos;
    pos = pos_idx % wrq_pkg::MAX_POINTS;
    if (!mean_seen[pos]) return rand_sample();
    return mean_mem[pos] + 16'($urandom_range(0, 200)) - 16'd100;
  endfunction

  // Send one item: draw a gap, raise valid, hold until accepted, then predict.
  task automatic send_item(input logic [1:0] kind, input logic [15:0] value,
                           input logic [15:0] id);
    wrq_pkg::wrq_in_t it;
    int               gap;
    // never compare a spike against a mean entry that was never loaded
    if (kind == wrq_pkg::REQ_SPIKE && !mean_seen[pos_idx % wrq_pkg::MAX_POINTS])
      kind = wrq_pkg::REQ_MEAN;
    it.req_type   = kind;
    it.sample     = value;
    it.cluster_id = id;
    gap = in_idle_en ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    score_item(it);
    if (kind != REQ_UNUSED) items_sent++;
  endtask

  // Hold the sender until every owed score is out, then let the pipe settle.
  task automatic wait_scores_done();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write n_points; only done with the block idle.
  task automatic write_points(input int unsigned v);
    wait_scores_done();
    cfg_valid <= 1'b1;
    cfg_data  <= wrq_pkg::N_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pts_reg = v % (1 << wrq_pkg::N_W);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // ------------------------------------------------------------------
  // Result side: random stall per result, compare against the oldest score
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_scores.size() == 0) begin
          report_mismatch("unexpected result, cluster_id",
                          64'(out_data.out_cluster_id), 64'(0));
        end else begin
          score_want = pending_scores.pop_front();
          if (out_data.out_cluster_id !== score_want.out_cluster_id)
            report_mismatch("out_cluster_id", 64'(out_data.out_cluster_id),
                            64'(score_want.out_cluster_id));
          if (out_data.mean_energy !== score_want.mean_energy)
            report_mismatch("mean_energy", 64'(out_data.mean_energy),
                            64'(score_want.mean_energy));
          if (out_data.resid_var !== score_want.resid_var)
            report_mismatch("resid_var", 64'(out_data.resid_var),
                            64'(score_want.resid_var));
          if (out_data.q_score !== score_want.q_score)
            report_mismatch("q_score", 64'(out_data.q_score),
                            64'(score_want.q_score));
          if (out_data.spike_count !== score_want.spike_count)
            report_mismatch("spike_count", 64'(out_data.spike_count),
                            64'(score_want.spike_count));
          if (out_data.status !== score_want.status)
            report_mismatch("status", 64'(out_data.status),
                            64'(score_want.status));
        end
        out_wait = out_idle_en ? $urandom_range(0, 11) : 0;
      end else if (out_valid && out_wait > 0) begin
        out_wait--;
      end
      out_ready <= (out_wait == 0);
    end
  end

  // ------------------------------------------------------------------
  // Directed tests
  // ------------------------------------------------------------------

  // Reset length of 1024: load every mean entry and close, then an empty cluster.
  task automatic test_default_length();
    int i;
    for (i = 0; i < 1024; i++) begin
      case (i)
        0:       send_item(wrq_pkg::REQ_MEAN, 16'h8000, 16'h1234);
        1:       send_item(wrq_pkg::REQ_MEAN, 16'h7FFF, 16'h1234);
        2:       send_item(wrq_pkg::REQ_MEAN, 16'h0000, 16'h1234);
        default: send_item(wrq_pkg::REQ_MEAN, rand_sample(), 16'h1234);
      endcase
    end
    send_item(wrq_pkg::REQ_END, 16'h0000, 16'hFFFF);
    // no samples at all: silent and spikeless, spikeless wins
    send_item(wrq_pkg::REQ_END, 16'hFFFF, 16'h0000);
  endtask

  // Register above the store size clamps to 1024, zero acts as one.
  task automatic test_points_clamp();
    write_points(2047);
    repeat (3) send_item(wrq_pkg::REQ_MEAN, 16'h8000, 16'h0001);
    send_item(wrq_pkg::REQ_END, 16'h0000, 16'h0002);
    write_points(0);
    send_item(wrq_pkg::REQ_MEAN, 16'd7, 16'h0003);
    send_item(wrq_pkg::REQ_SPIKE, -16'sd9, 16'h0003);
    send_item(wrq_pkg::REQ_END, 16'h0000, 16'h0004);
  endtask

  // Extreme sample values against extreme means: largest squared differences.
  task automatic test_field_extremes();
    write_points(4);
    send_item(wrq_pkg::REQ_MEAN, 16'h8000, 16'h0000);
    send_item(wrq_pkg::REQ_MEAN, 16'h7FFF, 16'hFFFF);
    send_item(wrq_pkg::REQ_MEAN, 16'h0000, 16'h0000);
    send_item(wrq_pkg::REQ_MEAN, 16'hFFFF, 16'hFFFF);
    send_item(wrq_pkg::REQ_SPIKE, 16'h7FFF, 16'h0000);
    send_item(wrq_pkg::REQ_SPIKE, 16'h8000, 16'hFFFF);
    send_item(wrq_pkg::REQ_SPIKE, 16'h0000, 16'h0000);
    send_item(wrq_pkg::REQ_SPIKE, 16'h0001, 16'hFFFF);
    send_item(wrq_pkg::REQ_END, 16'h7FFF, 16'hFFFF);
  endtask

  // Every status code, score saturation and mean energy saturation.
  task automatic test_status_codes();
    write_points(1);
    // silent cluster with a spike
    send_item(wrq_pkg::REQ_MEAN, 16'd0, 16'h0010);
    send_item(wrq_pkg::REQ_SPIKE, 16'd5, 16'h0010);
    send_item(wrq_pkg::REQ_END, 16'd0, 16'h0011);
    // silent and no spike together
    send_item(wrq_pkg::REQ_MEAN, 16'd0, 16'h0012);
    send_item(wrq_pkg::REQ_END, 16'd0, 16'h0013);
    // mean present, no spike
    send_item(wrq_pkg::REQ_MEAN, 16'd300, 16'h0014);
    send_item(wrq_pkg::REQ_END, 16'd0, 16'h0015);
    // tiny energy, large residual: score saturates
    send_item(wrq_pkg::REQ_MEAN, 16'd1, 16'h0016);
    send_item(wrq_pkg::REQ_SPIKE, 16'd1000, 16'h0016);
    send_item(wrq_pkg::REQ_END, 16'd0, 16'h0017);
    // repeated full-scale means overflow the 31-bit energy
    repeat (3) send_item(wrq_pkg::REQ_MEAN, 16'h8000, 16'h0018);
    send_item(wrq_pkg::REQ_SPIKE, 16'd0, 16'h0018);
    send_item(wrq_pkg::REQ_END, 16'd0, 16'h0019);
  endtask

  // A spike cut short by the end item is dropped.
  task automatic test_partial_spike();
    int i;
    write_points(4);
    for (i = 0; i < 4; i++) send_item(wrq_pkg::REQ_MEAN, rand_sample(), 16'h0020);
    for (i = 0; i < 6; i++) send_item(wrq_pkg::REQ_SPIKE, rand_sample(), 16'h0020);
    send_item(wrq_pkg::REQ_END, 16'd0, 16'h0021);
  endtask

  // Unused request code must neither move the position nor produce a result.
  task automatic test_unused_code();
    write_points(2);
    send_item(wrq_pkg::REQ_MEAN, 16'd40, 16'h0030);
    send_item(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
    send_item(wrq_pkg::REQ_MEAN, -16'sd40, 16'h0030);
    send_item(REQ_UNUSED, 16'h0000, 16'h0000);
    send_item(wrq_pkg::REQ_SPIKE, 16'd35, 16'h0030);
    send_item(wrq_pkg::REQ_SPIKE, -16'sd50, 16'h0030);
    send_item(REQ_UNUSED, 16'h8000, 16'h0030);
    send_item(wrq_pkg::REQ_END, 16'd0, 16'h0031);
  endtask

  // Mean sample inside a spike overwrites the store and adds energy.
  task automatic test_mixed_kinds();
    int i;
    write_points(4);
    for (i = 0; i < 4; i++) send_item(wrq_pkg::REQ_MEAN, rand_sample(), 16'h0040);
    send_item(wrq_pkg::REQ_SPIKE, rand_sample(), 16'h0040);
    send_item(wrq_pkg::REQ_SPIKE, rand_sample(), 16'h0040);
    send_item(wrq_pkg::REQ_MEAN, rand_sample(), 16'h0040);
    send_item(wrq_pkg::REQ_SPIKE, rand_sample(), 16'h0040);
    send_item(wrq_pkg::REQ_END, 16'd0, 16'h0041);
  endtask

  // Shrink the length while the position sits past the new last one.
  task automatic test_resize_midway();
    int i;
    write_points(8);
    for (i = 0; i < 5; i++) send_item(wrq_pkg::REQ_MEAN, rand_sample(), 16'h0050);
    write_points(3);
    send_item(wrq_pkg::REQ_MEAN, rand_sample(), 16'h0050);
    for (i = 0; i < 3; i++) send_item(wrq_pkg::REQ_SPIKE, near_mean(), 16'h0050);
    send_item(wrq_pkg::REQ_END, 16'd0, 16'h0051);
  endtask

  // ------------------------------------------------------------------
  // Random clusters: mostly well-formed, some broken or noisy streams
  // ------------------------------------------------------------------
  task automatic test_random_streams();
    int unsigned items0;
    int unsigned n;
    int unsigned mode;
    int unsigned i;
    int unsigned cnt;
    int unsigned clusters;
    int unsigned c;
    items0 = items_sent;
    while (items_sent - items0 < 560) begin
      // new setting for this phase, mostly short waveforms
      mode = $urandom_range(0, 9);
      if (mode == 0) write_points(0);
      else if (mode <= 6) write_points($urandom_range(1, 16));
      else write_points($urandom_range(17, 64));
      in_idle_en  = 1'($urandom_range(0, 1));
      out_idle_en = 1'($urandom_range(0, 1));
      clusters    = $urandom_range(1, 4);
      for (c = 0; c < clusters && items_sent - items0 < 560; c++) begin
        n = eff_points();
        if ($urandom_range(0, 4) != 0) begin
          for (i = 0; i < n; i++)
            send_item(wrq_pkg::REQ_MEAN, rand_sample(), 16'($urandom));
          cnt = n * $urandom_range(0, 4);
          for (i = 0; i < cnt; i++)
            send_item(wrq_pkg::REQ_SPIKE,
                      $urandom_range(0, 1) ? near_mean() : rand_sample(),
                      16'($urandom));
          // leave an unfinished spike now and then
          if (n > 1 && $urandom_range(0, 3) == 0) begin
            cnt = $urandom_range(1, n - 1);
            for (i = 0; i < cnt; i++)
              send_item(wrq_pkg::REQ_SPIKE, near_mean(), 16'($urandom));
          end
          if ($urandom_range(0, 7) == 0)
            send_item(REQ_UNUSED, rand_sample(), 16'($urandom));
          send_item(wrq_pkg::REQ_END, rand_sample(), 16'($urandom));
        end else begin
          // noise: any kind in any order, sometimes left open
          cnt = $urandom_range(1, 3 * n);
          for (i = 0; i < cnt; i++)
            send_item(2'($urandom_range(0, 3)), rand_sample(), 16'($urandom));
          if ($urandom_range(0, 4) != 0)
            send_item(wrq_pkg::REQ_END, rand_sample(), 16'($urandom));
        end
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_length();
    test_points_clamp();
    test_field_extremes();
    test_status_codes();
    test_partial_spike();
    test_unused_code();
    test_mixed_kinds();
    test_resize_midway();
    test_random_streams();
    // drain, then give the divider time to show any stray result
    wait_scores_done();
    repeat (250) @(posedge clk);
    if (err_count == 0) begin
      $display("[waveform_residual_quality_unit] OK");
    end else begin
      $display("[waveform_residual_quality_unit] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/wrq_pkg.sv
rtl/wrq_ram.sv
rtl/wrq_div.sv
rtl/wrq_dp.sv
rtl/wrq_ctrl.sv
rtl/waveform_residual_quality_unit.sv
tb/tb.sv
